>>> hw/rtl/sqr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sqr_pkg
// Shared constants, register layout and CRC8 step for the sensor query
// responder.
// ----------------------------------------------------------------------------
package sqr_pkg;

   localparam int DEFAULT_REQUEST_LENGTH = 4;

   localparam logic [7:0] REQ_PREFIX   = 8'h31;
   localparam logic [7:0] REPLY_PREFIX = 8'h3E;
   localparam logic [7:0] OP_READ      = 8'h06;

   localparam int REPLY_LENGTH = 9;
   localparam int REPLY_IDX_W  = $clog2(REPLY_LENGTH);

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_DEVICE_ADDRESS = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TEMPERATURE    = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_FUEL_LEVEL     = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_FREQUENCY      = 2'd3;

   localparam logic [7:0]  RESET_DEVICE_ADDRESS = 8'd165;
   localparam logic [7:0]  RESET_TEMPERATURE    = 8'd28;
   localparam logic [15:0] RESET_FUEL_LEVEL     = 16'd4660;
   localparam logic [15:0] RESET_FREQUENCY      = 16'd22136;

   typedef struct packed {
      logic [7:0]  device_address;
      logic [7:0]  temperature;
      logic [15:0] fuel_level;
      logic [15:0] frequency;
   } cfg_type;

   // Contribution of each bit of (data ^ crc) to the next reflected CRC8 value
   localparam logic [7:0] CRC_BIT_TERMS [8] = '{
      8'h5e, 8'hbc, 8'h61, 8'hc2, 8'h9d, 8'h23, 8'h46, 8'h8c
   };

   function automatic logic [7:0] crc_update(input logic [7:0] crc,
                                             input logic [7:0] data);
      logic [7:0] mix;
      logic [7:0] next;
      mix  = crc ^ data;
      next = 8'h00;
      for (int b = 0; b < 8; b++) begin
         if (mix[b]) begin
            next = next ^ CRC_BIT_TERMS[b];
         end
      end
      return next;
   endfunction

endpackage

>>> hw/rtl/sqr_frame_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sqr_frame_checker
// Counts received bytes into fixed-length request frames and checks prefix,
// operation and CRC on the fly; pulses frame_good after a valid frame.
// ----------------------------------------------------------------------------
module sqr_frame_checker #(
   parameter int REQUEST_LENGTH = sqr_pkg::DEFAULT_REQUEST_LENGTH
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       byte_accept,
   input  logic [7:0] rx_byte,
   output logic       frame_good
);

   localparam int POS_W = $clog2(REQUEST_LENGTH);
   localparam logic [POS_W-1:0] POS_LAST = POS_W'(REQUEST_LENGTH - 1);
   localparam logic [POS_W-1:0] POS_OP   = POS_W'(2);

   logic [POS_W-1:0] pos_ff, pos_in;
   logic [7:0]       crc_ff, crc_in;
   logic             prefix_ok_ff, prefix_ok_in;
   logic             op_ok_ff, op_ok_in;
   logic             good_ff, good_in;
   logic             op_ok_now;

   always_comb begin
      pos_in       = pos_ff;
      crc_in       = crc_ff;
      prefix_ok_in = prefix_ok_ff;
      op_ok_in     = op_ok_ff;
      good_in      = 1'b0;
      // on short frames the operation byte is also the last byte
      op_ok_now    = (pos_ff == POS_OP) ? (rx_byte == sqr_pkg::OP_READ) : op_ok_ff;
      if (byte_accept) begin
         if (pos_ff == '0) begin
            prefix_ok_in = (rx_byte == sqr_pkg::REQ_PREFIX);
            crc_in       = 8'h00;
         end else if (pos_ff != POS_LAST) begin
            crc_in = sqr_pkg::crc_update(crc_ff, rx_byte);
         end
         if (pos_ff == POS_OP) begin
            op_ok_in = (rx_byte == sqr_pkg::OP_READ);
         end
         if (pos_ff == POS_LAST) begin
            pos_in  = '0;
            good_in = prefix_ok_ff && (rx_byte == crc_ff) && op_ok_now;
         end else begin
            pos_in = pos_ff + POS_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         crc_ff       <= 8'h00;
         prefix_ok_ff <= 1'b0;
         op_ok_ff     <= 1'b0;
         good_ff      <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         crc_ff       <= crc_in;
         prefix_ok_ff <= prefix_ok_in;
         op_ok_ff     <= op_ok_in;
         good_ff      <= good_in;
      end
   end

   assign frame_good = good_ff;

   a_good_after_last: assert property (@(posedge clock) disable iff (reset)
      good_ff |-> $past(byte_accept) && $past(pos_ff) == POS_LAST)
      else $error("frame_good without a completed frame");

   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= POS_LAST)
      else $error("frame position beyond frame length");

endmodule

>>> hw/rtl/sqr_reply_gen.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sqr_reply_gen
// Sends the 9-byte reply for each good request, one byte per handshake,
// with the CRC built as bytes go out. Holds one further reply pending.
// ----------------------------------------------------------------------------
module sqr_reply_gen (
   input  logic             clock,
   input  logic             reset,
   input  logic             frame_good,
   input  sqr_pkg::cfg_type cfg,
   output logic             busy_full,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [7:0]       rsp_tx_byte,
   output logic             rsp_last_byte
);

   localparam int IDX_W = sqr_pkg::REPLY_IDX_W;
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(sqr_pkg::REPLY_LENGTH - 1);

   logic             active_ff, active_in;
   logic             pending_ff, pending_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [7:0]       crc_ff, crc_in;
   logic [7:0]       reply_bytes [sqr_pkg::REPLY_LENGTH];
   logic             take, finish;

   always_comb begin
      reply_bytes[0] = sqr_pkg::REPLY_PREFIX;
      reply_bytes[1] = cfg.device_address;
      reply_bytes[2] = sqr_pkg::OP_READ;
      reply_bytes[3] = cfg.temperature;
      reply_bytes[4] = cfg.fuel_level[7:0];
      reply_bytes[5] = cfg.fuel_level[15:8];
      reply_bytes[6] = cfg.frequency[7:0];
      reply_bytes[7] = cfg.frequency[15:8];
      reply_bytes[8] = crc_ff;
   end

   assign take   = active_ff && rsp_ready;
   assign finish = take && (idx_ff == IDX_LAST);

   always_comb begin
      active_in  = active_ff;
      pending_in = pending_ff;
      idx_in     = idx_ff;
      crc_in     = crc_ff;
      if (finish) begin
         // restart at once if another reply waits
         if (pending_ff || frame_good) begin
            idx_in = '0;
            crc_in = 8'h00;
         end else begin
            active_in = 1'b0;
         end
         pending_in = 1'b0;
      end else begin
         if (take) begin
            idx_in = idx_ff + IDX_W'(1);
            if (idx_ff != '0) begin
               crc_in = sqr_pkg::crc_update(crc_ff, rsp_tx_byte);
            end
         end
         if (frame_good) begin
            if (active_ff) begin
               pending_in = 1'b1;
            end else begin
               active_in = 1'b1;
               idx_in    = '0;
               crc_in    = 8'h00;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff  <= 1'b0;
         pending_ff <= 1'b0;
         idx_ff     <= '0;
         crc_ff     <= 8'h00;
      end else begin
         active_ff  <= active_in;
         pending_ff <= pending_in;
         idx_ff     <= idx_in;
         crc_ff     <= crc_in;
      end
   end

   assign busy_full     = pending_ff;
   assign rsp_valid     = active_ff;
   assign rsp_tx_byte   = reply_bytes[idx_ff];
   assign rsp_last_byte = (idx_ff == IDX_LAST);

   a_pending_needs_active: assert property (@(posedge clock) disable iff (reset)
      pending_ff |-> active_ff)
      else $error("reply pending while no reply in progress");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      frame_good |-> !pending_ff)
      else $error("good frame arrived with a reply already pending");

   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      active_ff |-> idx_ff <= IDX_LAST)
      else $error("reply index beyond reply length");

endmodule

>>> hw/rtl/sensor_query_responder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sensor_query_responder
// Answers fixed-length read requests from a serial byte stream with a
// 9-byte sensor reply.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : received bytes, one per valid/ready handshake. Bytes are counted
//            into frames of REQUEST_LENGTH bytes with no resynchronization.
//   rsp_*  : reply bytes, one per handshake; rsp_last_byte marks the ninth.
//   csr_*  : register writes (device address, temperature, level, frequency),
//            taken at once on csr_write_enable; write only while idle.
// Reply start: the first reply byte becomes valid once the last request
//   byte has passed the frame_good register and the reply-active register.
// Throughput: one request byte per cycle while req_ready is high; CRC and
//   checks are built as bytes arrive, so no frame buffer is read at the end.
//   One reply can wait behind the one being sent, holding req_ready low.
// Reset: frame position returns to zero, registers take their reset values,
//   and no reply is in progress.
// Stall: a stalled receiver holds the current reply byte; request bytes keep
//   being accepted until a second reply is queued.
// ----------------------------------------------------------------------------
module sensor_query_responder #(
   parameter int REQUEST_LENGTH = sqr_pkg::DEFAULT_REQUEST_LENGTH
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [7:0]                         req_rx_byte,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [7:0]                         rsp_tx_byte,
   output logic                               rsp_last_byte,
   input  logic                               csr_write_enable,
   input  logic [sqr_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [sqr_pkg::CSR_DATA_W-1:0]     csr_write_data
);

   sqr_pkg::cfg_type cfg_ff, cfg_in;
   logic             frame_good;
   logic             busy_full;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            sqr_pkg::CSR_DEVICE_ADDRESS: cfg_in.device_address = csr_write_data[7:0];
            sqr_pkg::CSR_TEMPERATURE:    cfg_in.temperature    = csr_write_data[7:0];
            sqr_pkg::CSR_FUEL_LEVEL:     cfg_in.fuel_level     = csr_write_data;
            sqr_pkg::CSR_FREQUENCY:      cfg_in.frequency      = csr_write_data;
            default:                     cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.device_address <= sqr_pkg::RESET_DEVICE_ADDRESS;
         cfg_ff.temperature    <= sqr_pkg::RESET_TEMPERATURE;
         cfg_ff.fuel_level     <= sqr_pkg::RESET_FUEL_LEVEL;
         cfg_ff.frequency      <= sqr_pkg::RESET_FREQUENCY;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign req_ready = !busy_full;

   sqr_frame_checker #(
      .REQUEST_LENGTH(REQUEST_LENGTH)
   ) u_checker (
      .clock      (clock),
      .reset      (reset),
      .byte_accept(req_valid && req_ready),
      .rx_byte    (req_rx_byte),
      .frame_good (frame_good)
   );

   sqr_reply_gen u_reply (
      .clock        (clock),
      .reset        (reset),
      .frame_good   (frame_good),
      .cfg          (cfg_ff),
      .busy_full    (busy_full),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_tx_byte  (rsp_tx_byte),
      .rsp_last_byte(rsp_last_byte)
   );

endmodule
